@@ rtl/frcb_pkg.sv @@
// Shared constants, codes and types of the failure-ratio circuit breaker table.
`timescale 1ns / 1ps
package frcb_pkg;

  // Table size and field widths.
  localparam int NUM_SLOTS = 64;
  localparam int SLOT_W    = 6;
  localparam int TAG_W     = 32;
  localparam int TIME_W    = 32;
  localparam int SPAN_W    = 31;
  localparam int THR_W     = 14;
  localparam int CNT_W     = 32;
  localparam int PROD_W    = CNT_W + THR_W;

  // Slots the slot field can actually address.
  localparam int TBL_DEPTH = (NUM_SLOTS < (2 ** SLOT_W)) ? NUM_SLOTS : (2 ** SLOT_W);
  localparam int ADDR_W    = (TBL_DEPTH > 1) ? $clog2(TBL_DEPTH) : 1;

  localparam int MIN_ATTEMPTS = 20;
  localparam int BP_SCALE     = 10000;

  typedef enum logic {
    CMD_ALLOW  = 1'b0,
    CMD_REPORT = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    MODE_CLOSED = 2'd0,
    MODE_HALF   = 2'd1,
    MODE_OPEN   = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_MUL,
    ST_DONE
  } state_t;

  // One breaker slot as stored in the table.
  typedef struct packed {
    logic [TAG_W-1:0]  tag;
    mode_t             mode;
    logic [TIME_W-1:0] probe_time;
    logic [TIME_W-1:0] window_start;
    logic [CNT_W-1:0]  attempt_count;
    logic [CNT_W-1:0]  failure_count;
  } slot_entry_t;

  // Write port of the slot table.
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    slot_entry_t       entry;
  } tbl_wr_t;

endpackage

@@ rtl/frcb_req_if.sv @@
// Request channel of the breaker table: valid/ready handshake with the query payload.
`timescale 1ns / 1ps
interface frcb_req_if;
  logic                         valid;
  logic                         ready;
  logic                         cmd;
  logic [frcb_pkg::SLOT_W-1:0]  slot;
  logic [frcb_pkg::TAG_W-1:0]   owner_tag;
  logic [frcb_pkg::TIME_W-1:0]  now_ms;
  logic                         timeout_seen;
  logic                         enabled;
  logic [frcb_pkg::SPAN_W-1:0]  probe_interval_ms;
  logic [frcb_pkg::SPAN_W-1:0]  window_ms;
  logic [frcb_pkg::THR_W-1:0]   threshold_bp;

  modport source (
    output valid, cmd, slot, owner_tag, now_ms, timeout_seen, enabled,
           probe_interval_ms, window_ms, threshold_bp,
    input  ready
  );

  modport sink (
    input  valid, cmd, slot, owner_tag, now_ms, timeout_seen, enabled,
           probe_interval_ms, window_ms, threshold_bp,
    output ready
  );
endinterface

@@ rtl/frcb_rsp_if.sv @@
// Response channel of the breaker table: valid/ready handshake with the decision payload.
`timescale 1ns / 1ps
interface frcb_rsp_if;
  logic       valid;
  logic       ready;
  logic       allowed;
  logic [1:0] breaker_mode;
  logic       opened_now;

  modport source (
    output valid, allowed, breaker_mode, opened_now,
    input  ready
  );

  modport sink (
    input  valid, allowed, breaker_mode, opened_now,
    output ready
  );
endinterface

@@ rtl/frcb_table.sv @@
// Slot table memory with per-entry valid bits so that unwritten slots read as reset.
`timescale 1ns / 1ps
module frcb_table (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          rd_en,
  input  logic [frcb_pkg::ADDR_W-1:0]   rd_addr,
  output frcb_pkg::slot_entry_t         rd_entry,
  input  frcb_pkg::tbl_wr_t             wr
);

  frcb_pkg::slot_entry_t            mem [frcb_pkg::TBL_DEPTH];
  frcb_pkg::slot_entry_t            rd_data;
  logic [frcb_pkg::TBL_DEPTH-1:0]   vld;
  logic                             rd_vld;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.entry;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (wr.en) begin
        vld[wr.addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld <= vld[rd_addr];
      end
    end
  end

  // A slot never written since reset reads as the all-zero reset entry.
  assign rd_entry = rd_vld ? rd_data : '0;

endmodule

@@ rtl/failure_ratio_circuit_breaker_top.sv @@
// Top level of the failure-ratio circuit breaker table: control, update datapath, output.
`timescale 1ns / 1ps
// Usage:
// The req channel carries one event per transfer: an allow query (cmd 0) or a
// result report (cmd 1) for one breaker slot, together with the caller's tag,
// the current time and the per-caller settings. The rsp channel returns exactly
// one transfer per request with the allow decision, the slot mode after the
// event and a flag that marks the event that opened the breaker.
// Each request goes through these steps in order: the table read is issued in
// the cycle the request transfers, the next cycle updates the slot, the step
// after that forms the two ratio products, and the final step compares them,
// writes the slot back and loads the response register. A new request is
// taken only while the sequencer is idle, so the block does not take a new
// request before it has finished the last one.
// Synchronous reset empties the response register and marks every slot as never
// written, so all slots read as closed with zero tag, times and counters; no
// clearing pass is needed. If the receiver holds rsp.ready low, the finished
// response stays in its register; the block still takes one more request, works
// it through and then waits in its final step, without taking another request,
// until the held response has been transferred.
module failure_ratio_circuit_breaker_top (
  input logic           clk,
  input logic           rst,
  frcb_req_if.sink      req,
  frcb_rsp_if.source    rsp
);

  frcb_pkg::state_t state, state_next;

  // Request captured at transfer.
  logic                           cmd;
  logic [frcb_pkg::SLOT_W-1:0]    slot;
  logic [frcb_pkg::TAG_W-1:0]     tag;
  logic [frcb_pkg::TIME_W-1:0]    now;
  logic                           tmo;
  logic                           en;
  logic [frcb_pkg::SPAN_W-1:0]    probe;
  logic [frcb_pkg::SPAN_W-1:0]    win;
  logic [frcb_pkg::THR_W-1:0]     thr;

  // Results of the update step.
  frcb_pkg::slot_entry_t          work, work_next;
  logic                           allowed, allowed_next;
  logic                           opened, opened_next;
  logic                           check, check_next;
  logic                           wr_back, wr_back_next;

  // Ratio products: failures * scale against threshold * attempts.
  logic [frcb_pkg::PROD_W-1:0]    prod_f;
  logic [frcb_pkg::PROD_W-1:0]    prod_t;

  // Response register.
  logic                           rsp_valid;
  logic                           rsp_allowed;
  logic [1:0]                     rsp_mode;
  logic                           rsp_opened;

  frcb_pkg::slot_entry_t          rd_entry;
  frcb_pkg::tbl_wr_t              wr;
  frcb_pkg::slot_entry_t          final_entry;

  logic                           req_fire;
  logic                           rsp_free;
  logic                           trip;

  assign req_fire = req.valid && req.ready;
  assign rsp_free = !rsp_valid || rsp.ready;

  frcb_table u_table (
    .clk      (clk),
    .rst      (rst),
    .rd_en    (req_fire),
    .rd_addr  (req.slot[frcb_pkg::ADDR_W-1:0]),
    .rd_entry (rd_entry),
    .wr       (wr)
  );

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= frcb_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    req.ready  = 1'b0;
    case (state)
      frcb_pkg::ST_IDLE: begin
        req.ready = 1'b1;
        if (req.valid) begin
          state_next = frcb_pkg::ST_CALC;
        end
      end
      frcb_pkg::ST_CALC: begin
        state_next = frcb_pkg::ST_MUL;
      end
      frcb_pkg::ST_MUL: begin
        state_next = frcb_pkg::ST_DONE;
      end
      frcb_pkg::ST_DONE: begin
        if (rsp_free) begin
          state_next = frcb_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = frcb_pkg::ST_IDLE;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Request capture
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (req_fire) begin
      cmd   <= req.cmd;
      slot  <= req.slot;
      tag   <= req.owner_tag;
      now   <= req.now_ms;
      tmo   <= req.timeout_seen;
      en    <= req.enabled;
      probe <= req.probe_interval_ms;
      win   <= req.window_ms;
      thr   <= req.threshold_bp;
    end
  end

  // ---------------------------------------------------------------------------
  // Update step: tag check, probe timing, window expiry, counting and the
  // half-open transitions. The closed-mode ratio test is left for later steps.
  // ---------------------------------------------------------------------------
  frcb_pkg::slot_entry_t          base;
  logic [frcb_pkg::TIME_W-1:0]    d_probe;
  logic [frcb_pkg::TIME_W-1:0]    d_win;
  logic                           win_expired;
  logic [frcb_pkg::CNT_W-1:0]     a0, f0, a1, f1;
  logic                           in_range;

  assign in_range = {1'b0, slot} < (frcb_pkg::SLOT_W + 1)'(frcb_pkg::TBL_DEPTH);

  always_comb begin
    base = rd_entry;
    // A different owner takes over the slot from a clean reset state.
    if (base.tag != tag) begin
      base     = '0;
      base.tag = tag;
    end

    d_probe     = now - base.probe_time;
    d_win       = now - base.window_start;
    // Time differences are read as signed: a negative gap has not come yet.
    win_expired = !d_win[frcb_pkg::TIME_W-1] && (d_win >= {1'b0, win});

    a0 = win_expired ? '0 : base.attempt_count;
    f0 = win_expired ? '0 : base.failure_count;
    a1 = (a0 == '1) ? a0 : a0 + 1'b1;
    f1 = (tmo && f0 != '1) ? f0 + 1'b1 : f0;

    work_next    = base;
    allowed_next = 1'b0;
    opened_next  = 1'b0;
    check_next   = 1'b0;
    wr_back_next = 1'b1;

    if (!in_range) begin
      work_next      = '0;
      allowed_next   = (cmd == frcb_pkg::CMD_ALLOW);
      wr_back_next   = 1'b0;
    end else if (!en) begin
      // Disabled callers leave the slot alone and see its stored mode.
      work_next      = rd_entry;
      allowed_next   = (cmd == frcb_pkg::CMD_ALLOW);
      wr_back_next   = 1'b0;
    end else if (cmd == frcb_pkg::CMD_ALLOW) begin
      if (base.mode == frcb_pkg::MODE_CLOSED) begin
        allowed_next = 1'b1;
      end else if (!d_probe[frcb_pkg::TIME_W-1]) begin
        work_next.probe_time = now + {1'b0, probe};
        work_next.mode       = frcb_pkg::MODE_HALF;
        allowed_next         = 1'b1;
      end
    end else begin
      if (win_expired) begin
        work_next.window_start = now;
      end
      work_next.attempt_count = a1;
      work_next.failure_count = f1;
      case (base.mode)
        frcb_pkg::MODE_HALF: begin
          work_next.window_start  = now;
          work_next.attempt_count = '0;
          work_next.failure_count = '0;
          if (tmo) begin
            work_next.probe_time = now + {1'b0, probe};
            work_next.mode       = frcb_pkg::MODE_OPEN;
            opened_next          = 1'b1;
          end else begin
            work_next.mode       = frcb_pkg::MODE_CLOSED;
          end
        end
        frcb_pkg::MODE_CLOSED: begin
          check_next = (a1 >= frcb_pkg::CNT_W'(frcb_pkg::MIN_ATTEMPTS)) && (f1 != '0);
        end
        default: begin
          // An open slot only counts.
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == frcb_pkg::ST_CALC) begin
      work    <= work_next;
      allowed <= allowed_next;
      opened  <= opened_next;
      check   <= check_next;
      wr_back <= wr_back_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Ratio products. floor(f * 10000 / a) >= thr holds exactly when
  // f * 10000 >= thr * a, so no divider is needed.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (state == frcb_pkg::ST_MUL) begin
      prod_f <= frcb_pkg::PROD_W'(work.failure_count) *
                frcb_pkg::PROD_W'(frcb_pkg::BP_SCALE);
      prod_t <= frcb_pkg::PROD_W'(thr) * frcb_pkg::PROD_W'(work.attempt_count);
    end
  end

  // ---------------------------------------------------------------------------
  // Final step: trip decision, write-back and response.
  // ---------------------------------------------------------------------------
  assign trip = check && (prod_f >= prod_t);

  always_comb begin
    final_entry = work;
    if (trip) begin
      final_entry.probe_time    = now + {1'b0, probe};
      final_entry.window_start  = now;
      final_entry.attempt_count = '0;
      final_entry.failure_count = '0;
      final_entry.mode          = frcb_pkg::MODE_OPEN;
    end
  end

  always_comb begin
    wr.en    = (state == frcb_pkg::ST_DONE) && wr_back && rsp_free;
    wr.addr  = slot[frcb_pkg::ADDR_W-1:0];
    wr.entry = final_entry;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if ((state == frcb_pkg::ST_DONE) && rsp_free) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == frcb_pkg::ST_DONE) && rsp_free) begin
      rsp_allowed <= allowed;
      rsp_mode    <= final_entry.mode;
      rsp_opened  <= opened || trip;
    end
  end

  assign rsp.valid        = rsp_valid;
  assign rsp.allowed      = rsp_allowed;
  assign rsp.breaker_mode = rsp_mode;
  assign rsp.opened_now   = rsp_opened;

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  a_fire_starts_update: assert property (@(posedge clk) disable iff (rst)
    req_fire |=> state == frcb_pkg::ST_CALC)
    else $error("request transfer did not start the update sequence");

  a_write_only_at_done: assert property (@(posedge clk) disable iff (rst)
    wr.en |-> (state == frcb_pkg::ST_DONE) && en && in_range)
    else $error("slot table written outside the final step of an enabled request");

  a_opened_means_open: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.opened_now |-> rsp.breaker_mode == frcb_pkg::MODE_OPEN && !rsp.allowed)
    else $error("breaker reported opened but response mode is not open");

  a_trip_only_closed_report: assert property (@(posedge clk) disable iff (rst)
    (state == frcb_pkg::ST_DONE) && trip |-> cmd == frcb_pkg::CMD_REPORT && en
      && work.mode == frcb_pkg::MODE_CLOSED)
    else $error("ratio trip outside a closed-mode report");

endmodule
